// File: rtl/rcef_pkg.sv
// ----------------------------------------------------------------------------
// rcef_pkg
// Shared types, widths and helpers of the 3x3 RGB extremum filter.
// ----------------------------------------------------------------------------
package rcef_pkg;

   localparam int MAX_DIM    = 1024;
   localparam int POS_W      = $clog2(MAX_DIM);
   localparam int EDIM_W     = POS_W + 1;
   localparam int DIM_W      = 11;
   localparam int COORD_W    = 10;
   localparam int CH_W       = 8;
   localparam int W_W        = 7;
   localparam int TAPS       = 9;
   localparam int TAP_W      = 4;
   localparam int KW_W       = 63;
   localparam int DIV_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 63;
   localparam int PROD_W     = 16;
   localparam int SUM_W      = 20;
   localparam int QUO_W      = 18;
   localparam int QCNT_W     = 5;
   localparam int LUMA_W     = 10;
   localparam int LUMA_MAX   = 766;
   localparam int CH_MAX     = 255;

   localparam logic [KW_W-1:0]  KERNEL_RESET = 63'd72624976668147841;
   localparam logic [DIV_W-1:0] SCALE_RESET  = 10'd9;
   localparam logic [DIM_W-1:0] DIM_RESET    = 11'd1024;

   typedef logic [2:0][CH_W-1:0] pixel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL = 2'd0,
      CSR_SCALE  = 2'd1,
      CSR_FILTER = 2'd2,
      CSR_DIM    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [KW_W-1:0]  kernel;
      logic [DIV_W-1:0] scale;
      logic             filter;
      logic [DIM_W-1:0] dim;
   } cfg_type;

   typedef struct packed {
      pixel_type [TAPS-1:0] win;
      logic [COORD_W-1:0]   int_row;
      logic [COORD_W-1:0]   int_col;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      pixel_type            px;
      logic                 has_int;
      logic                 has_bord;
   } job_type;

   function automatic logic signed [W_W-1:0] weight_at(input logic [KW_W-1:0] kw,
                                                       input logic [TAP_W-1:0] k);
      logic [W_W-1:0] w;
      w = kw[W_W*k +: W_W];
      return $signed(w);
   endfunction

endpackage

// File: rtl/rcef_req_if.sv
// ----------------------------------------------------------------------------
// rcef_req_if
// Request channel: one raster-order RGB pixel per request.
// ----------------------------------------------------------------------------
interface rcef_req_if;
   logic                      valid;
   logic                      ready;
   logic [rcef_pkg::CH_W-1:0] in_red;
   logic [rcef_pkg::CH_W-1:0] in_green;
   logic [rcef_pkg::CH_W-1:0] in_blue;

   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

// File: rtl/rcef_rsp_if.sv
// ----------------------------------------------------------------------------
// rcef_rsp_if
// Response channel: one filtered or passed-through pixel with coordinates.
// ----------------------------------------------------------------------------
interface rcef_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rcef_pkg::COORD_W-1:0] out_row;
   logic [rcef_pkg::COORD_W-1:0] out_col;
   logic [rcef_pkg::CH_W-1:0]    out_red;
   logic [rcef_pkg::CH_W-1:0]    out_green;
   logic [rcef_pkg::CH_W-1:0]    out_blue;
   logic                         run_last;

   modport source (output valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue, run_last,
                   output ready);
endinterface

// File: rtl/rcef_front.sv
// ----------------------------------------------------------------------------
// rcef_front
// Accepts pixels, keeps line stores and the 3x3 window, classifies each
// request as interior and/or border and queues the work.
// ----------------------------------------------------------------------------
module rcef_front (
   input  logic                  clock,
   input  logic                  reset,
   input  rcef_pkg::cfg_type     cfg,
   rcef_req_if.sink              req_bus,
   output logic                  push,
   output rcef_pkg::job_type     push_job,
   input  logic                  full
);
   import rcef_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_LOAD = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;

   pixel_type upper_mem [MAX_DIM];
   pixel_type lower_mem [MAX_DIM];

   pixel_type            rd_upper_ff, rd_lower_ff;
   pixel_type            px_ff;
   pixel_type [TAPS-1:0] win_ff;
   logic [POS_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic [POS_W-1:0]     r_ff, c_ff;
   logic                 has_int_ff, has_bord_ff;

   logic [EDIM_W-1:0]    edim;
   logic [EDIM_W-1:0]    r_pre, c_pre;
   logic [EDIM_W-1:0]    r_nxt, c_nxt;
   logic                 take;
   logic                 is_int, is_bord;

   always_comb begin
      if (int'(cfg.dim) < 3) begin
         edim = EDIM_W'(3);
      end else if (int'(cfg.dim) > MAX_DIM) begin
         edim = EDIM_W'(MAX_DIM);
      end else begin
         edim = EDIM_W'(cfg.dim);
      end
   end

   assign take          = (state_ff == F_IDLE) && req_bus.valid;
   assign req_bus.ready = (state_ff == F_IDLE);

   always_comb begin
      r_pre = {1'b0, row_ff};
      c_pre = {1'b0, col_ff};
      if (c_pre >= edim) begin
         c_pre = '0;
         r_pre = r_pre + 1'b1;
      end
      if (r_pre >= edim) begin
         r_pre = '0;
      end
   end

   always_comb begin
      c_nxt = {1'b0, c_ff} + 1'b1;
      r_nxt = {1'b0, r_ff};
      if (c_nxt >= edim) begin
         c_nxt = '0;
         r_nxt = r_nxt + 1'b1;
         if (r_nxt >= edim) begin
            r_nxt = '0;
         end
      end
   end

   assign is_int  = (r_ff >= POS_W'(2)) && (c_ff >= POS_W'(2));
   assign is_bord = (r_ff == '0) || (c_ff == '0) ||
                    ({1'b0, r_ff} == edim - 1'b1) || ({1'b0, c_ff} == edim - 1'b1);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         F_IDLE: begin
            if (take) begin
               state_in = F_LOAD;
            end
         end
         F_LOAD: begin
            row_in   = r_nxt[POS_W-1:0];
            col_in   = c_nxt[POS_W-1:0];
            state_in = (is_int || is_bord) ? F_PUSH : F_IDLE;
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_upper_ff <= upper_mem[c_pre[POS_W-1:0]];
      rd_lower_ff <= lower_mem[c_pre[POS_W-1:0]];
      if (state_ff == F_LOAD) begin
         upper_mem[c_ff] <= rd_lower_ff;
         lower_mem[c_ff] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         px_ff[0] <= req_bus.in_red;
         px_ff[1] <= req_bus.in_green;
         px_ff[2] <= req_bus.in_blue;
         r_ff     <= r_pre[POS_W-1:0];
         c_ff     <= c_pre[POS_W-1:0];
      end
      if (state_ff == F_LOAD) begin
         win_ff[0]   <= win_ff[1];
         win_ff[1]   <= win_ff[2];
         win_ff[2]   <= rd_upper_ff;
         win_ff[3]   <= win_ff[4];
         win_ff[4]   <= win_ff[5];
         win_ff[5]   <= rd_lower_ff;
         win_ff[6]   <= win_ff[7];
         win_ff[7]   <= win_ff[8];
         win_ff[8]   <= px_ff;
         has_int_ff  <= is_int;
         has_bord_ff <= is_bord;
      end
   end

   assign push              = (state_ff == F_PUSH) && !full;
   assign push_job.win      = win_ff;
   assign push_job.int_row  = COORD_W'(r_ff - 1'b1);
   assign push_job.int_col  = COORD_W'(c_ff - 1'b1);
   assign push_job.row      = COORD_W'(r_ff);
   assign push_job.col      = COORD_W'(c_ff);
   assign push_job.px       = px_ff;
   assign push_job.has_int  = has_int_ff;
   assign push_job.has_bord = has_bord_ff;

endmodule

// File: rtl/rcef_queue.sv
// ----------------------------------------------------------------------------
// rcef_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module rcef_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rcef_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output rcef_pkg::job_type pop_job,
   output logic              empty
);
   import rcef_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [PTR_W:0]     cnt_ff;

   assign full    = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/rcef_back.sv
// ----------------------------------------------------------------------------
// rcef_back
// Works off queued jobs: weighted window sum, extremum removal, serial
// division and clamp, then drives the responses.
// ----------------------------------------------------------------------------
module rcef_back (
   input  logic              clock,
   input  logic              reset,
   input  rcef_pkg::cfg_type cfg,
   input  rcef_pkg::job_type pop_job,
   input  logic              empty,
   output logic              pop,
   rcef_rsp_if.source        rsp_bus
);
   import rcef_pkg::*;

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_ACC  = 6'b000010,
      B_SUB  = 6'b000100,
      B_DIV  = 6'b001000,
      B_INT  = 6'b010000,
      B_BORD = 6'b100000
   } bstate_type;

   bstate_type state_ff, state_in;

   job_type                  job_ff;
   logic [TAP_W-1:0]         k_ff;
   logic [QCNT_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic [DIV_W-1:0]         rem_ff [3];
   logic [QUO_W-1:0]         quo_ff [3];
   logic [LUMA_W-1:0]        lo_ff, hi_ff;
   pixel_type                lo_px_ff, hi_px_ff;
   logic [CH_W-1:0]          res_ff [3];

   pixel_type                tap;
   logic signed [W_W-1:0]    w;
   logic signed [PROD_W-1:0] prod [3];
   logic [LUMA_W-1:0]        luma;
   logic [DIV_W-1:0]         dvs;
   logic signed [SUM_W-1:0]  adj [3];
   logic [DIV_W:0]           trial [3];
   logic                     ge [3];

   assign tap  = job_ff.win[k_ff];
   assign w    = weight_at(cfg.kernel, k_ff);
   assign luma = LUMA_W'(tap[0]) + LUMA_W'(tap[1]) + LUMA_W'(tap[2]);
   assign dvs  = (cfg.scale == '0) ? DIV_W'(1) : cfg.scale;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch]  = $signed({1'b0, tap[ch]}) * w;
         adj[ch]   = sum_ff[ch];
         if (cfg.filter) begin
            adj[ch] = sum_ff[ch] -
                      $signed(SUM_W'({1'b0, lo_px_ff[ch]} + {1'b0, hi_px_ff[ch]}));
         end
         trial[ch] = {rem_ff[ch], quo_ff[ch][QUO_W-1]};
         ge[ch]    = (trial[ch] >= {1'b0, dvs});
      end
   end

   assign pop = (state_ff == B_IDLE) && !empty;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               state_in = pop_job.has_int ? B_ACC : B_BORD;
            end
         end
         B_ACC: begin
            if (k_ff == TAP_W'(TAPS - 1)) begin
               state_in = B_SUB;
            end
         end
         B_SUB: state_in = B_DIV;
         B_DIV: begin
            if (cnt_ff == QCNT_W'(QUO_W - 1)) begin
               state_in = B_INT;
            end
         end
         B_INT: begin
            if (rsp_bus.ready) begin
               state_in = job_ff.has_bord ? B_BORD : B_IDLE;
            end
         end
         B_BORD: begin
            if (rsp_bus.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            job_ff <= pop_job;
            k_ff   <= '0;
            lo_ff  <= LUMA_W'(LUMA_MAX);
            hi_ff  <= '0;
            for (int ch = 0; ch < 3; ch++) begin
               sum_ff[ch] <= '0;
            end
         end
         B_ACC: begin
            k_ff <= k_ff + 1'b1;
            for (int ch = 0; ch < 3; ch++) begin
               sum_ff[ch] <= sum_ff[ch] + SUM_W'(prod[ch]);
            end
            if (luma <= lo_ff) begin
               lo_ff    <= luma;
               lo_px_ff <= tap;
            end
            if ((k_ff == '0) || (luma > hi_ff)) begin
               hi_ff    <= luma;
               hi_px_ff <= tap;
            end
         end
         B_SUB: begin
            cnt_ff <= '0;
            for (int ch = 0; ch < 3; ch++) begin
               rem_ff[ch] <= '0;
               quo_ff[ch] <= (adj[ch] > 0) ? QUO_W'(adj[ch]) : '0;
            end
         end
         B_DIV: begin
            cnt_ff <= cnt_ff + 1'b1;
            for (int ch = 0; ch < 3; ch++) begin
               rem_ff[ch] <= ge[ch] ? DIV_W'(trial[ch] - {1'b0, dvs}) : DIV_W'(trial[ch]);
               quo_ff[ch] <= {quo_ff[ch][QUO_W-2:0], ge[ch]};
               if (cnt_ff == QCNT_W'(QUO_W - 1)) begin
                  res_ff[ch] <= (|quo_ff[ch][QUO_W-2:CH_W-1]) ? CH_W'(CH_MAX)
                                : {quo_ff[ch][CH_W-2:0], ge[ch]};
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid     = (state_ff == B_INT) || (state_ff == B_BORD);
   assign rsp_bus.out_row   = (state_ff == B_INT) ? job_ff.int_row : job_ff.row;
   assign rsp_bus.out_col   = (state_ff == B_INT) ? job_ff.int_col : job_ff.col;
   assign rsp_bus.out_red   = (state_ff == B_INT) ? res_ff[0] : job_ff.px[0];
   assign rsp_bus.out_green = (state_ff == B_INT) ? res_ff[1] : job_ff.px[1];
   assign rsp_bus.out_blue  = (state_ff == B_INT) ? res_ff[2] : job_ff.px[2];
   assign rsp_bus.run_last  = (state_ff == B_BORD) || !job_ff.has_bord;

endmodule

// File: rtl/rgb_conv3x3_extremum_filter.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_extremum_filter
// Streaming 3x3 weighted RGB filter with optional extremum removal.
//
//   channel   role      payload
//   req_bus   sink      in_red, in_green, in_blue
//   rsp_bus   source    out_row, out_col, out_red/green/blue, run_last
//   csr_*     write     csr_index selects kernel, scale, filter, dim
//
// Front accepts a pixel only while idle, reads the line stores in load and
// pushes the job, or returns to idle when the pixel yields no response; a
// full queue holds it in push. Back pops a job, sums the nine weighted taps,
// removes the extrema and divides bit-serially per interior result, then
// holds each response until taken; a 2-entry queue lets the front run ahead.
// Reset is synchronous and clears positions, queue and state machines; line
// stores need no clear.
// ----------------------------------------------------------------------------
module rgb_conv3x3_extremum_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rcef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcef_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   rcef_req_if.sink                            req_bus,
   rcef_rsp_if.source                          rsp_bus
);
   import rcef_pkg::*;

   cfg_type cfg_ff;
   job_type push_job, pop_job;
   logic    push, pop, full, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel <= KERNEL_RESET;
         cfg_ff.scale  <= SCALE_RESET;
         cfg_ff.filter <= 1'b0;
         cfg_ff.dim    <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_KERNEL: cfg_ff.kernel <= csr_wr_data[KW_W-1:0];
            CSR_SCALE:  cfg_ff.scale  <= csr_wr_data[DIV_W-1:0];
            CSR_FILTER: cfg_ff.filter <= csr_wr_data[0];
            CSR_DIM:    cfg_ff.dim    <= csr_wr_data[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rcef_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_bus  (req_bus),
      .push     (push),
      .push_job (push_job),
      .full     (full)
   );

   rcef_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   rcef_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pop_job  (pop_job),
      .empty    (empty),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

// File: rtl/rcef_checker.sv
// ----------------------------------------------------------------------------
// rcef_checker
// Port-level checks of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module rcef_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rcef_pkg::COORD_W-1:0] rsp_row,
   input logic [rcef_pkg::COORD_W-1:0] rsp_col,
   input logic [rcef_pkg::CH_W-1:0]    rsp_red,
   input logic                         rsp_last
);

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col))
      else $error("stalled response dropped or changed");

   a_red_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_last))
      else $error("stalled response payload changed");

   a_border_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("border response did not follow interior response");

   a_interior_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_row != '0 && rsp_col != '0)
      else $error("non-final response is not an interior pixel");

endmodule

bind rgb_conv3x3_extremum_filter rcef_checker u_rcef_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_row   (rsp_bus.out_row),
   .rsp_col   (rsp_bus.out_col),
   .rsp_red   (rsp_bus.out_red),
   .rsp_last  (rsp_bus.run_last)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams square RGB images through the 3x3 extremum filter under changing
// kernel, scale, filter and size settings. Every response is checked, field
// by field and in order, against a pixel-level prediction of the line stores,
// the window and the arithmetic; the sender and receiver idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import rcef_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [CH_W-1:0]    red;
      logic [CH_W-1:0]    green;
      logic [CH_W-1:0]    blue;
      logic               last;
   } pix_result_type;

   typedef enum logic {STEP_PIXEL, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type       kind;
      csr_idx_type         idx;
      logic [KW_W-1:0]     data;
      pixel_type           px;
      logic                typed;
      logic [COORD_W-1:0]  exp_row;
      logic [COORD_W-1:0]  exp_col;
   } step_type;

   localparam int DIR_STEPS = 22;
   localparam int RAND_PIXELS = 800;
   localparam int WIDE_PIXELS = MAX_DIM / 8;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   rcef_req_if req_bus ();
   rcef_rsp_if rsp_bus ();

   rgb_conv3x3_extremum_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source)
   );

   // shadow of the block's registers and pixel state
   logic [KW_W-1:0]  kernel_sh;
   logic [DIV_W-1:0] scale_sh;
   logic             filter_sh;
   logic [DIM_W-1:0] dim_sh;
   pixel_type        upper_line [MAX_DIM];
   pixel_type        lower_line [MAX_DIM];
   pixel_type        window [TAPS];
   int               row_pos;
   int               col_pos;

   pix_result_type   pending_pixels [$];
   int               errors;
   int               tx_idle_pct;
   int               rx_stall_pct;
   bit               hold_trigger;
   int               hold_left;
   int               pixels_sent;

   step_type dir_steps [DIR_STEPS] = '{
      '{STEP_CSR,   CSR_DIM,    63'd0,          24'h0,      1'b0, 10'd0, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h000000, 1'b1, 10'd0, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'hffffff, 1'b1, 10'd0, 10'd1},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h0000ff, 1'b1, 10'd0, 10'd2},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h00ff00, 1'b1, 10'd1, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'hff0000, 1'b0, 10'd0, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h808080, 1'b1, 10'd1, 10'd2},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h030201, 1'b1, 10'd2, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'hfcfdfe, 1'b1, 10'd2, 10'd1},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h7f7f7f, 1'b1, 10'd2, 10'd2},
      '{STEP_CSR,   CSR_FILTER, 63'd1,          24'h0,      1'b0, 10'd0, 10'd0},
      '{STEP_CSR,   CSR_KERNEL, {9{7'h3f}},     24'h0,      1'b0, 10'd0, 10'd0},
      '{STEP_CSR,   CSR_SCALE,  63'd1023,       24'h0,      1'b0, 10'd0, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h0000ff, 1'b1, 10'd0, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h00ff00, 1'b1, 10'd0, 10'd1},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'hff0000, 1'b1, 10'd0, 10'd2},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h000000, 1'b1, 10'd1, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h555555, 1'b0, 10'd0, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h000000, 1'b1, 10'd1, 10'd2},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'hffffff, 1'b1, 10'd2, 10'd0},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'hffffff, 1'b1, 10'd2, 10'd1},
      '{STEP_PIXEL, CSR_KERNEL, 63'd0,          24'h7f8081, 1'b1, 10'd2, 10'd2}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void predict_pixel(pixel_type px);
      int d;
      int r;
      int c;
      int dv;
      int sum [3];
      int lo;
      int hi;
      int lo_k;
      int hi_k;
      int luma;
      int q;
      int n0;
      logic signed [W_W-1:0] w;
      pix_result_type res;
      d = (dim_sh < 3) ? 3 : (dim_sh > MAX_DIM) ? MAX_DIM : int'(dim_sh);
      if (col_pos >= d) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= d) row_pos = 0;
      r = row_pos;
      c = col_pos;
      for (int k = 0; k < 3; k++) begin
         window[k*3]   = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = upper_line[c];
      window[5] = lower_line[c];
      window[8] = px;
      upper_line[c] = lower_line[c];
      lower_line[c] = px;
      n0 = pending_pixels.size();
      if (r >= 2 && c >= 2) begin
         dv = (scale_sh == 0) ? 1 : int'(scale_sh);
         for (int ch = 0; ch < 3; ch++) sum[ch] = 0;
         for (int k = 0; k < TAPS; k++) begin
            w = kernel_sh[W_W*k +: W_W];
            for (int ch = 0; ch < 3; ch++) sum[ch] += int'(window[k][ch]) * int'(w);
         end
         if (filter_sh) begin
            lo = LUMA_MAX;
            hi = -1;
            lo_k = 0;
            hi_k = 0;
            for (int k = 0; k < TAPS; k++) begin
               luma = int'(window[k][0]) + int'(window[k][1]) + int'(window[k][2]);
               if (luma <= lo) begin
                  lo = luma;
                  lo_k = k;
               end
               if (luma > hi) begin
                  hi = luma;
                  hi_k = k;
               end
            end
            for (int ch = 0; ch < 3; ch++)
               sum[ch] -= int'(window[lo_k][ch]) + int'(window[hi_k][ch]);
         end
         for (int ch = 0; ch < 3; ch++) begin
            q = sum[ch] / dv;
            if (q < 0) q = 0;
            if (q > CH_MAX) q = CH_MAX;
            sum[ch] = q;
         end
         res = '{COORD_W'(r - 1), COORD_W'(c - 1), CH_W'(sum[0]), CH_W'(sum[1]),
                 CH_W'(sum[2]), 1'b0};
         pending_pixels.push_back(res);
      end
      if (r == 0 || c == 0 || r == d - 1 || c == d - 1) begin
         res = '{COORD_W'(r), COORD_W'(c), px[0], px[1], px[2], 1'b0};
         pending_pixels.push_back(res);
      end
      if (pending_pixels.size() > n0) pending_pixels[$].last = 1'b1;
      col_pos = c + 1;
      if (col_pos >= d) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= d) row_pos = 0;
      end
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      for (int ch = 0; ch < 3; ch++)
         case ($urandom_range(5))
            0: px[ch] = 8'd0;
            1: px[ch] = 8'd255;
            default: px[ch] = CH_W'($urandom);
         endcase
      return px;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_pixel(pixel_type px, logic typed, logic [COORD_W-1:0] er,
                             logic [COORD_W-1:0] ec);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_red   <= px[0];
      req_bus.in_green <= px[1];
      req_bus.in_blue  <= px[2];
      do @(posedge clock); while (!req_bus.ready);
      predict_pixel(px);
      if (typed) begin
         pending_pixels[$].row   = er;
         pending_pixels[$].col   = ec;
         pending_pixels[$].red   = px[0];
         pending_pixels[$].green = px[1];
         pending_pixels[$].blue  = px[2];
      end
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (64) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_KERNEL: kernel_sh = data[KW_W-1:0];
         CSR_SCALE:  scale_sh  = data[DIV_W-1:0];
         CSR_FILTER: filter_sh = data[0];
         CSR_DIM:    dim_sh    = data[DIM_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic send_images(int n);
      int d;
      d = (dim_sh < 3) ? 3 : (dim_sh > MAX_DIM) ? MAX_DIM : int'(dim_sh);
      repeat (n * d * d) send_pixel(random_pixel(), 1'b0, '0, '0);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_trigger) begin
         hold_trigger = 1'b0;
         hold_left = 400;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      pix_result_type got;
      pix_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_red, rsp_bus.out_green,
                 rsp_bus.out_blue, rsp_bus.run_last};
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t unexpected response row %0d col %0d rgb %h %h %h last %b", $time,
                     got.row, got.col, got.red, got.green, got.blue, got.last);
         end else begin
            want = pending_pixels.pop_front();
            if (got.row !== want.row || got.col !== want.col || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.last !== want.last) begin
               errors++;
               $display("%0t expected row %0d col %0d rgb %h %h %h last %b", $time,
                        want.row, want.col, want.red, want.green, want.blue, want.last);
               $display("%0t actual   row %0d col %0d rgb %h %h %h last %b", $time,
                        got.row, got.col, got.red, got.green, got.blue, got.last);
            end
         end
      end
   end

   initial begin
      logic [KW_W-1:0] kern;
      errors = 0;
      pixels_sent = 0;
      hold_trigger = 1'b0;
      hold_left = 0;
      tx_idle_pct = 10;
      rx_stall_pct = 76;
      kernel_sh = KERNEL_RESET;
      scale_sh = SCALE_RESET;
      filter_sh = 1'b0;
      dim_sh = DIM_RESET;
      row_pos = 0;
      col_pos = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.in_red = '0;
      req_bus.in_green = '0;
      req_bus.in_blue = '0;
      rsp_bus.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_steps[i]) begin
         if (dir_steps[i].kind == STEP_CSR) begin
            drain();
            write_csr(dir_steps[i].idx, dir_steps[i].data);
         end else begin
            send_pixel(dir_steps[i].px, dir_steps[i].typed, dir_steps[i].exp_row,
                       dir_steps[i].exp_col);
         end
      end

      pixels_sent = 0;
      while (pixels_sent < RAND_PIXELS) begin
         drain();
         if (pixels_sent >= 2 * RAND_PIXELS / 3) begin
            if (tx_idle_pct != 0) hold_trigger = 1'b1;
            tx_idle_pct = 0;
            rx_stall_pct = 0;
         end else if (pixels_sent >= RAND_PIXELS / 3) begin
            tx_idle_pct = 76;
            rx_stall_pct = 10;
         end
         case ($urandom_range(3))
            0: kern = KW_W'({$urandom, $urandom});
            1: for (int k = 0; k < TAPS; k++) kern[W_W*k +: W_W] = W_W'($urandom_range(6) - 3);
            2: kern = {9{7'h40}};
            default: kern = KERNEL_RESET;
         endcase
         write_csr(CSR_KERNEL, kern);
         case ($urandom_range(4))
            0: write_csr(CSR_SCALE, CSR_DATA_W'(0));
            1: write_csr(CSR_SCALE, CSR_DATA_W'(1));
            2: write_csr(CSR_SCALE, CSR_DATA_W'(1023));
            default: write_csr(CSR_SCALE, CSR_DATA_W'($urandom_range(1, 64)));
         endcase
         write_csr(CSR_FILTER, CSR_DATA_W'($urandom_range(1)));
         write_csr(CSR_DIM, CSR_DATA_W'(($urandom_range(9) < 8) ? $urandom_range(3, 7)
                                                                 : $urandom_range(2)));
         send_images($urandom_range(1, 2));
      end

      // part of the first row at the largest size
      drain();
      write_csr(CSR_KERNEL, CSR_DATA_W'({$urandom, $urandom}));
      write_csr(CSR_SCALE, CSR_DATA_W'($urandom_range(1, 1023)));
      write_csr(CSR_FILTER, CSR_DATA_W'($urandom_range(1)));
      write_csr(CSR_DIM, CSR_DATA_W'(2047));
      repeat (WIDE_PIXELS) send_pixel(random_pixel(), 1'b0, '0, '0);
      drain();

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
